// ===== src/sbc_pkg.sv =====
// Shared constants, types and fixed-point helpers for the stereo biquad cascade.
// Used by sbc_cell, stereo_biquad_cascade_unit and its checker; no dependencies.
package sbc_pkg;

   localparam int MAX_BANDS   = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 32;
   localparam int COEF_INT    = 4;
   localparam int DELAY_BITS  = 48;
   localparam int STATE_FRAC  = 40;
   localparam int SLOTS       = 5;
   localparam int PROD_SHIFT  = (SAMPLE_BITS - 1) + (COEF_BITS - COEF_INT) - STATE_FRAC;
   localparam int OUT_SHIFT   = STATE_FRAC - (SAMPLE_BITS - 1);
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS    = DELAY_BITS + 4;
   localparam int BAND_BITS   = 3;
   localparam int SLOT_BITS   = 3;
   localparam int CMD_BITS    = 2;
   localparam int CNT_BITS    = 4;
   localparam int REQ_BYTES   = (2 * SAMPLE_BITS + BAND_BITS + SLOT_BITS + COEF_BITS + 7) / 8;
   localparam int REQ_BITS    = 8 * REQ_BYTES;
   localparam int RSP_BITS    = 8 * ((2 * SAMPLE_BITS + 7) / 8);

   localparam logic [CMD_BITS-1:0] CMD_PROCESS = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [SLOT_BITS-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_BITS-1:0] SLOT_A2 = 3'd4;

   localparam logic signed [ACC_BITS-1:0] DLY_MAX =
      $signed({{(ACC_BITS-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}});
   localparam logic signed [ACC_BITS-1:0] DLY_MIN = -DLY_MAX - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] SMP_MAX =
      $signed({{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [ACC_BITS-1:0] SMP_MIN = -SMP_MAX - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] ROUND_ADD = ACC_BITS'(1) <<< (OUT_SHIFT - 1);

   typedef struct packed {
      logic                          start;
      logic                          enable;
      logic signed [SAMPLE_BITS-1:0] x_l;
      logic signed [SAMPLE_BITS-1:0] x_r;
   } cell_in_type;

   typedef struct packed {
      logic                          done;
      logic signed [SAMPLE_BITS-1:0] y_l;
      logic signed [SAMPLE_BITS-1:0] y_r;
   } cell_out_type;

   typedef struct packed {
      logic                        we;
      logic                        clear;
      logic [SLOT_BITS-1:0]        slot;
      logic signed [COEF_BITS-1:0] value;
   } cell_wr_type;

   function automatic logic signed [DELAY_BITS-1:0] sat_delay(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] r;
      r = v;
      if (v > DLY_MAX) r = DLY_MAX;
      if (v < DLY_MIN) r = DLY_MIN;
      return r[DELAY_BITS-1:0];
   endfunction

   // Q8.40 accumulator to Q1.23, round half up, saturate
   function automatic logic signed [SAMPLE_BITS-1:0] round_out(
      input logic signed [DELAY_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] t;
      logic signed [ACC_BITS-1:0] s;
      t = ACC_BITS'(acc) + ROUND_ADD;
      s = t >>> OUT_SHIFT;
      if (s > SMP_MAX) s = SMP_MAX;
      if (s < SMP_MIN) s = SMP_MIN;
      return s[SAMPLE_BITS-1:0];
   endfunction

endpackage

// ===== src/sbc_cell.sv =====
// One biquad section of the cascade: coefficients, both channels' delays, shared multiplier.
// Depends on sbc_pkg.
module sbc_cell import sbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_in_type  cin,
   input  cell_wr_type  wr,
   output cell_out_type cout
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                     state_ff, state_in;
   logic [2:0]                    step_ff, step_in;
   logic                          ch_ff, ch_in;
   logic                          done_ff, done_in;
   logic signed [SAMPLE_BITS-1:0] xl_ff, xl_in, xr_ff, xr_in;
   logic signed [SAMPLE_BITS-1:0] yl_ff, yl_in, yr_ff, yr_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [DELAY_BITS-1:0]  acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]    t_ff, t_in;
   logic signed [COEF_BITS-1:0]   coef_ff [SLOTS];
   logic signed [DELAY_BITS-1:0]  z_ff [4];
   logic signed [DELAY_BITS-1:0]  z_in [4];

   logic signed [COEF_BITS-1:0]   m_coef;
   logic signed [SAMPLE_BITS-1:0] m_data, x_cur;
   logic signed [ACC_BITS-1:0]    psh;
   logic [1:0]                    z1_idx, z2_idx;

   assign x_cur  = ch_ff ? xr_ff : xl_ff;
   assign psh    = ACC_BITS'(prod_ff >>> PROD_SHIFT);
   assign z1_idx = {ch_ff, 1'b0};
   assign z2_idx = {ch_ff, 1'b1};
   assign prod_in = m_coef * m_data;

   // step 0 b0*x, 1 acc and b1*x, 2 y, 3 a1*y, 4 b2*x, 5 z1 and a2*y, 6 z2
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ch_in    = ch_ff;
      done_in  = 1'b0;
      xl_in    = xl_ff;
      xr_in    = xr_ff;
      yl_in    = yl_ff;
      yr_in    = yr_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;
      z_in     = z_ff;
      m_coef   = coef_ff[SLOT_B0];
      m_data   = x_cur;
      case (step_ff)
         3'd1: m_coef = coef_ff[SLOT_B1];
         3'd3: begin
            m_coef = coef_ff[SLOT_A1];
            m_data = y_ff;
         end
         3'd4: m_coef = coef_ff[SLOT_B2];
         3'd5: begin
            m_coef = coef_ff[SLOT_A2];
            m_data = y_ff;
         end
         default: m_coef = coef_ff[SLOT_B0];
      endcase
      case (state_ff)
         ST_IDLE: begin
            if (cin.start) begin
               if (cin.enable) begin
                  state_in = ST_RUN;
                  step_in  = 3'd0;
                  ch_in    = 1'b0;
                  xl_in    = cin.x_l;
                  xr_in    = cin.x_r;
               end else begin
                  done_in = 1'b1;
                  yl_in   = cin.x_l;
                  yr_in   = cin.x_r;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: acc_in = sat_delay(psh + ACC_BITS'(z_ff[z1_idx]));
               3'd2: begin
                  y_in = round_out(acc_ff);
                  t_in = psh + ACC_BITS'(z_ff[z2_idx]);
               end
               3'd4: t_in = t_ff - psh;
               3'd5: begin
                  z_in[z1_idx] = sat_delay(t_ff);
                  t_in = psh;
               end
               3'd6: begin
                  z_in[z2_idx] = sat_delay(t_ff - psh);
                  step_in = 3'd0;
                  if (ch_ff) begin
                     yr_in    = y_ff;
                     done_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     yl_in = y_ff;
                     ch_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
      if (wr.clear) begin
         for (int k = 0; k < 4; k++) z_in[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= 3'd0;
         ch_ff    <= 1'b0;
         for (int k = 0; k < 4; k++) z_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
         ch_ff    <= ch_in;
         z_ff     <= z_in;
      end
      xl_ff   <= xl_in;
      xr_ff   <= xr_in;
      yl_ff   <= yl_in;
      yr_ff   <= yr_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      if (wr.we) coef_ff[wr.slot[$clog2(SLOTS)-1:0]] <= wr.value;
   end

   assign cout.done = done_ff;
   assign cout.y_l  = yl_ff;
   assign cout.y_r  = yr_ff;

endmodule

// ===== src/stereo_biquad_cascade_unit.sv =====
// Top level of the stereo biquad cascade: request decode, chain of section cells, output register.
// Depends on sbc_pkg and sbc_cell.
//
// A process request walks a row of MAX_BANDS section cells, one cell per band. Each active
// cell runs its section on left then right through its own multiplier and hands its
// output to the next cell in the cycle after its last step; an inactive cell passes its
// input on through its output registers. The input turns ready again in the same cycle as
// the response turns valid, so a new frame request is not taken before the previous frame
// has left the cells. One frame is in flight at a time; the result sits in an output
// register, so the next request is taken while it waits. Coefficient write and clear
// requests leave the input ready and give no response. Coefficients are undefined until
// written; delay state resets to zero and is zeroed by a clear request.
module stereo_biquad_cascade_unit import sbc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // lsb up: left_in[23:0], right_in[47:24], band_sel[50:48], coef_sel[53:51],
   // coef_value[85:54], zero pad
   input  logic [REQ_BITS-1:0] req_tdata,
   // cmd[1:0]
   input  logic [CMD_BITS-1:0] req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // lsb up: left_out[23:0], right_out[47:24]
   output logic [RSP_BITS-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic [CNT_BITS-1:0] csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_type;

   localparam int L_LO = 0;
   localparam int R_LO = SAMPLE_BITS;
   localparam int B_LO = 2 * SAMPLE_BITS;
   localparam int S_LO = B_LO + BAND_BITS;
   localparam int C_LO = S_LO + SLOT_BITS;

   state_type                     state_ff, state_in;
   logic [CNT_BITS-1:0]           bands_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [2*SAMPLE_BITS-1:0]      rsp_data_ff, rsp_data_in;
   logic [2*SAMPLE_BITS-1:0]      pend_ff, pend_in;

   logic                          accept;
   logic [CNT_BITS-1:0]           n_use;
   logic [BAND_BITS-1:0]          band_sel;
   logic [SLOT_BITS-1:0]          coef_sel;
   cell_in_type                   cin  [MAX_BANDS];
   cell_out_type                  cout [MAX_BANDS];
   cell_wr_type                   cwr  [MAX_BANDS];
   cell_out_type                  last;
   logic                          slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign band_sel   = req_tdata[B_LO +: BAND_BITS];
   assign coef_sel   = req_tdata[S_LO +: SLOT_BITS];
   assign n_use      = (bands_ff > CNT_BITS'(MAX_BANDS)) ? CNT_BITS'(MAX_BANDS) : bands_ff;
   assign last       = cout[MAX_BANDS-1];
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // chain: cell i starts when cell i-1 hands over its section output
   for (genvar i = 0; i < MAX_BANDS; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cin[i].start = accept && (req_tuser == CMD_PROCESS);
         assign cin[i].x_l   = req_tdata[L_LO +: SAMPLE_BITS];
         assign cin[i].x_r   = req_tdata[R_LO +: SAMPLE_BITS];
      end else begin : g_link
         assign cin[i].start = cout[i-1].done;
         assign cin[i].x_l   = cout[i-1].y_l;
         assign cin[i].x_r   = cout[i-1].y_r;
      end
      assign cin[i].enable = (CNT_BITS'(i) < n_use);
      // band_sel beyond the store or slot above a2 writes nothing
      assign cwr[i].we    = accept && (req_tuser == CMD_WRITE) &&
                            (32'(band_sel) == i) && (coef_sel <= SLOT_A2);
      assign cwr[i].clear = accept && (req_tuser == CMD_CLEAR);
      assign cwr[i].slot  = coef_sel;
      assign cwr[i].value = req_tdata[C_LO +: COEF_BITS];

      sbc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cin   (cin[i]),
         .wr    (cwr[i]),
         .cout  (cout[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == CMD_PROCESS)) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last.done) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {last.y_r, last.y_l};
                  state_in     = ST_IDLE;
               end else begin
                  pend_in  = {last.y_r, last.y_l};
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bands_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) bands_ff <= csr_wdata;
      end
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_data_ff);

endmodule

// ===== src/sbc_checker.sv =====
// Port-level checks for stereo_biquad_cascade_unit, bound to every instance.
// Depends on sbc_pkg and stereo_biquad_cascade_unit.
module sbc_checker import sbc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [CMD_BITS-1:0] req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response dropped or changed");

   a_process_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == CMD_PROCESS)) |=> !req_tready)
      else $error("frame request did not occupy the cascade");

   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != CMD_PROCESS)) |=> req_tready)
      else $error("write or clear request stalled the input");

endmodule

bind stereo_biquad_cascade_unit sbc_checker u_sbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
